// ===== hdl/ect_pkg.sv =====
// Package for the ear clip triangulator: sizes, types and state codes.
// No dependencies.
`timescale 1ns / 1ps
package ect_pkg;
  localparam int MaxVertsDefault = 16;
  localparam int CoordW = 24;

  typedef logic signed [CoordW-1:0] coord_t;

  // Sequencer states, one-hot
  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_CLOSE  = 14'b00000000000010,
    S_AREA   = 14'b00000000000100,
    S_REV    = 14'b00000000001000,
    S_INIT   = 14'b00000000010000,
    S_CORNER = 14'b00000000100000,
    S_CVX    = 14'b00000001000000,
    S_SCAN   = 14'b00000010000000,
    S_TRI    = 14'b00000100000000,
    S_EMIT   = 14'b00001000000000,
    S_SHIFT  = 14'b00010000000000,
    S_FAN    = 14'b00100000000000,
    S_FEMIT  = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;
endpackage

// ===== hdl/ear_clip_triangulator.sv =====
// Ear clip triangulator top level: vertex store, sequencer and output register.
// Depends on ect_pkg and ect_cross.
//
// Usage: send polygon vertices on the input channel (vert_x, vert_z,
// last_vertex; valid/stall). Vertices load one per cycle while the block is
// collecting. Up to MAX_VERTS are held; more are discarded and every
// triangle of that polygon carries dropped_vertices. The request with
// last_vertex starts triangulation; the input stalls until every triangle
// has been taken. Triangles leave on the output channel one per request,
// final_triangle marking the last. For n vertices the steps are a closing
// check, a shoelace sum, a reversal if the polygon is clockwise, index setup.
// Per clipped ear, up to m corner tests run; a convex corner then scans the
// m listed vertices, testing each one that is not a corner of the ear
// against the triangle. Emitting and removing the ear follow, and the
// vertices left at the end leave as fan triangles before the block closes.
// All products go through one shared cross product unit with registered
// products. An output stall holds the sequencer only when it has a new
// triangle or the end while the last is untaken. Synchronous reset returns
// the block to collecting with an empty store and no triangle pending.
`timescale 1ns / 1ps
module ear_clip_triangulator #(
  parameter int MAX_VERTS = ect_pkg::MaxVertsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ect_pkg::coord_t vert_x,
  input  ect_pkg::coord_t vert_z,
  input  logic last_vertex,
  output logic out_valid,
  input  logic out_stall,
  output ect_pkg::coord_t corner_a_x,
  output ect_pkg::coord_t corner_a_z,
  output ect_pkg::coord_t corner_b_x,
  output ect_pkg::coord_t corner_b_z,
  output ect_pkg::coord_t corner_c_x,
  output ect_pkg::coord_t corner_c_z,
  output logic final_triangle,
  output logic dropped_vertices
);
  localparam int IW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  ect_pkg::coord_t sx [MAX_VERTS];
  ect_pkg::coord_t sz [MAX_VERTS];
  logic [IW-1:0] ord [MAX_VERTS];
  logic [CW-1:0] cnt, n, m, i, k, j;
  logic ovf;
  ect_pkg::state_t st;
  logic signed [63:0] area;
  logic [1:0] sub;         // triangle edge sub-step / pipeline phase
  logic neg, pos;
  logic [IW-1:0] pa, pb, pc, q;
  logic [IW-1:0] o_i, a_i, b_i;
  logic org_zero;
  ect_pkg::coord_t op_ox, op_oz;
  logic signed [51:0] prod;
  logic have_tri;
  logic [CW-1:0] i_nx;
  logic [CW-1:0] m1;
  logic [CW-1:0] i_prev, i_next;
  logic [IW-1:0] cnt_last;
  logic closing;
  logic out_free, out_load;

  assign i_nx = (i + 1'b1 == n) ? '0 : i + 1'b1;
  assign m1 = m - 1'b1;
  assign j = n - 1'b1 - i;
  assign i_prev = (i == '0) ? m1 : i - 1'b1;
  assign i_next = (i == m1) ? '0 : i + 1'b1;

  // closing vertex equal to the first
  assign cnt_last = cnt[IW-1:0] - 1'b1;
  assign closing = (cnt > CW'(1)) && sx[0] == sx[cnt_last] && sz[0] == sz[cnt_last];

  // Cross unit operand selection; shoelace terms use a zero origin
  always_comb begin
    o_i = pa; a_i = pb; b_i = pc;
    org_zero = 1'b0;
    case (st)
      ect_pkg::S_AREA: begin
        org_zero = 1'b1;
        a_i = i[IW-1:0];
        b_i = i_nx[IW-1:0];
      end
      ect_pkg::S_SCAN, ect_pkg::S_TRI: begin
        case (sub)
          2'd0: begin o_i = pa; a_i = pb; b_i = q; end
          2'd1: begin o_i = pb; a_i = pc; b_i = q; end
          default: begin o_i = pc; a_i = pa; b_i = q; end
        endcase
      end
      default: ;
    endcase
  end

  assign op_ox = org_zero ? '0 : sx[o_i];
  assign op_oz = org_zero ? '0 : sz[o_i];

  ect_cross u_cross (
    .clk(clk),
    .ox(op_ox), .oz(op_oz),
    .ax(sx[a_i]), .az(sz[a_i]),
    .bx(sx[b_i]), .bz(sz[b_i]),
    .prod(prod)
  );

  assign in_stall = (st != ect_pkg::S_LOAD);

  // Output register handshake
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && (st == ect_pkg::S_EMIT || st == ect_pkg::S_FEMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ect_pkg::S_LOAD;
      cnt <= '0;
      ovf <= 1'b0;
    end else begin
      case (st)
        ect_pkg::S_LOAD: begin
          if (in_valid) begin
            if (cnt < CW'(MAX_VERTS)) begin
              sx[cnt[IW-1:0]] <= vert_x;
              sz[cnt[IW-1:0]] <= vert_z;
              cnt <= cnt + 1'b1;
            end else ovf <= 1'b1;
            if (last_vertex) st <= ect_pkg::S_CLOSE;
          end
        end
        ect_pkg::S_CLOSE: begin
          // leave out closing vertex equal to the first
          n <= closing ? cnt - 1'b1 : cnt;
          i <= '0; sub <= '0; area <= '0;
          if (cnt < CW'(3) || (cnt == CW'(3) && closing))
            st <= ect_pkg::S_DONE;
          else st <= ect_pkg::S_AREA;
        end
        ect_pkg::S_AREA: begin
          // product ready the cycle after issue: sub marks a valid product
          if (sub == 2'd1) area <= area + 64'(prod);
          if (sub == 2'd0) sub <= 2'd1;
          else if (i + 1'b1 == n) begin
            sub <= 2'd0;
            i <= '0;
            st <= ect_pkg::S_REV;
          end else begin
            i <= i + 1'b1;
            sub <= 2'd0;
          end
        end
        ect_pkg::S_REV: begin
          if (area < 0 && i < (n >> 1)) begin
            sx[i[IW-1:0]] <= sx[j[IW-1:0]]; sx[j[IW-1:0]] <= sx[i[IW-1:0]];
            sz[i[IW-1:0]] <= sz[j[IW-1:0]]; sz[j[IW-1:0]] <= sz[i[IW-1:0]];
            i <= i + 1'b1;
          end else begin
            i <= '0;
            st <= ect_pkg::S_INIT;
          end
        end
        ect_pkg::S_INIT: begin
          ord[i[IW-1:0]] <= i[IW-1:0];
          if (i + 1'b1 == n) begin
            m <= n; i <= '0;
            st <= (n > CW'(3)) ? ect_pkg::S_CORNER : ect_pkg::S_FAN;
          end else begin
            i <= i + 1'b1;
          end
        end
        ect_pkg::S_CORNER: begin
          if (i == m) begin
            i <= CW'(1);
            st <= ect_pkg::S_FAN;
          end else begin
            pa <= ord[i_prev[IW-1:0]];
            pb <= ord[i[IW-1:0]];
            pc <= ord[i_next[IW-1:0]];
            sub <= 2'd0;
            st <= ect_pkg::S_CVX;
          end
        end
        ect_pkg::S_CVX: begin
          // wait for the registered product
          if (sub == 2'd0) sub <= 2'd1;
          else if (prod <= 0) begin
            i <= i + 1'b1; st <= ect_pkg::S_CORNER;
          end else begin
            k <= '0; st <= ect_pkg::S_SCAN;
          end
        end
        ect_pkg::S_SCAN: begin
          if (k == m) begin
            have_tri <= 1'b0;
            st <= ect_pkg::S_EMIT;
          end else begin
            q <= ord[k[IW-1:0]];
            if (ord[k[IW-1:0]] == pa || ord[k[IW-1:0]] == pb || ord[k[IW-1:0]] == pc)
              k <= k + 1'b1;
            else begin
              neg <= 1'b0; pos <= 1'b0; sub <= 2'd0;
              have_tri <= 1'b0;
              st <= ect_pkg::S_TRI;
            end
          end
        end
        ect_pkg::S_TRI: begin
          // the triangle's three sides, each issued and then its registered result checked
          if (!have_tri) have_tri <= 1'b1;
          else begin
            have_tri <= 1'b0;
            if (sub == 2'd2) begin
              if (!((neg || prod < 0) && (pos || prod > 0))) begin
                i <= i + 1'b1; st <= ect_pkg::S_CORNER;
              end else begin
                k <= k + 1'b1; st <= ect_pkg::S_SCAN;
              end
            end else begin
              neg <= neg || prod < 0;
              pos <= pos || prod > 0;
              sub <= sub + 1'b1;
            end
          end
        end
        ect_pkg::S_EMIT: begin
          if (out_free) begin
            corner_a_x <= sx[pa]; corner_a_z <= sz[pa];
            corner_b_x <= sx[pb]; corner_b_z <= sz[pb];
            corner_c_x <= sx[pc]; corner_c_z <= sz[pc];
            final_triangle <= 1'b0;
            dropped_vertices <= ovf;
            k <= i;
            st <= ect_pkg::S_SHIFT;
          end
        end
        ect_pkg::S_SHIFT: begin
          if (k + 1'b1 < m) begin
            ord[k[IW-1:0]] <= ord[k[IW-1:0] + 1'b1];
            k <= k + 1'b1;
          end else begin
            m <= m1;
            if (m1 > CW'(3)) begin
              i <= '0;
              st <= ect_pkg::S_CORNER;
            end else begin
              i <= CW'(1);
              st <= ect_pkg::S_FAN;
            end
          end
        end
        ect_pkg::S_FAN: begin
          i <= (i == '0) ? CW'(1) : i;
          st <= ect_pkg::S_FEMIT;
        end
        ect_pkg::S_FEMIT: begin
          if (out_free) begin
            corner_a_x <= sx[ord[0]]; corner_a_z <= sz[ord[0]];
            corner_b_x <= sx[ord[i[IW-1:0]]]; corner_b_z <= sz[ord[i[IW-1:0]]];
            corner_c_x <= sx[ord[i[IW-1:0] + 1'b1]];
            corner_c_z <= sz[ord[i[IW-1:0] + 1'b1]];
            final_triangle <= (i + 2'd2 == m);
            dropped_vertices <= ovf;
            if (i + 2'd2 == m) st <= ect_pkg::S_DONE;
            else i <= i + 1'b1;
          end
        end
        ect_pkg::S_DONE: begin
          if (out_free) begin
            cnt <= '0; ovf <= 1'b0;
            st <= ect_pkg::S_LOAD;
          end
        end
        default: st <= ect_pkg::S_LOAD;
      endcase
    end
  end
endmodule

// ===== hdl/ect_cross.sv =====
// Shared cross product unit: (a-o) x (b-o), products registered, then subtracted.
// Uses ect_pkg.
`timescale 1ns / 1ps
module ect_cross (
  input  logic clk,
  input  ect_pkg::coord_t ox,
  input  ect_pkg::coord_t oz,
  input  ect_pkg::coord_t ax,
  input  ect_pkg::coord_t az,
  input  ect_pkg::coord_t bx,
  input  ect_pkg::coord_t bz,
  output logic signed [51:0] prod
);
  logic signed [24:0] dax, daz, dbx, dbz;
  logic signed [49:0] p1, p2;

  always_comb begin
    dax = 25'(ax) - 25'(ox);
    daz = 25'(az) - 25'(oz);
    dbx = 25'(bx) - 25'(ox);
    dbz = 25'(bz) - 25'(oz);
  end

  // register products, then subtract
  always_ff @(posedge clk) begin
    p1 <= dax * dbz;
    p2 <= daz * dbx;
  end

  assign prod = 52'(p1) - 52'(p2);
endmodule

// ===== tb/sv/ear_clip_triangulator_tb.sv =====
// Testbench for ear_clip_triangulator: polygons in, triangles checked against
// a built-in ear clipping predictor. Depends on ect_pkg and the block's RTL.
`timescale 1ns / 1ps
module ear_clip_triangulator_tb;

  localparam int MaxV = ect_pkg::MaxVertsDefault;
  localparam int LongHold = 400;

  typedef struct {
    ect_pkg::coord_t ax, az, bx, bz, cx, cz;
    logic   fin, drop;
  } tri_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  ect_pkg::coord_t vert_x = '0;
  ect_pkg::coord_t vert_z = '0;
  logic   last_vertex = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  ect_pkg::coord_t corner_a_x, corner_a_z, corner_b_x, corner_b_z;
  ect_pkg::coord_t corner_c_x, corner_c_z;
  logic   final_triangle, dropped_vertices;

  ear_clip_triangulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vert_x(vert_x), .vert_z(vert_z), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .corner_a_x(corner_a_x), .corner_a_z(corner_a_z),
    .corner_b_x(corner_b_x), .corner_b_z(corner_b_z),
    .corner_c_x(corner_c_x), .corner_c_z(corner_c_z),
    .final_triangle(final_triangle), .dropped_vertices(dropped_vertices)
  );

  always #1 clk = ~clk;

  // Predictor state
  longint poly_x [MaxV];
  longint poly_z [MaxV];
  int     live_idx [MaxV];
  int     held_count = 0;
  bit     lost_any = 0;
  tri_t   pending_tris [$];

  int  fail_count = 0;
  int  items_sent = 0;
  bit  quiet = 0;
  bit  hold_request = 0;

  function automatic longint cross3(int o, int a, int b);
    longint ax = poly_x[a] - poly_x[o];
    longint az = poly_z[a] - poly_z[o];
    longint bx = poly_x[b] - poly_x[o];
    longint bz = poly_z[b] - poly_z[o];
    return ax * bz - az * bx;
  endfunction

  function automatic bit in_or_on(int p, int a, int b, int c);
    longint d1 = cross3(a, b, p);
    longint d2 = cross3(b, c, p);
    longint d3 = cross3(c, a, p);
    bit neg = (d1 < 0) || (d2 < 0) || (d3 < 0);
    bit pos = (d1 > 0) || (d2 > 0) || (d3 > 0);
    return !(neg && pos);
  endfunction

  function automatic void push_tri(int a, int b, int c);
    tri_t t;
    t.ax = ect_pkg::coord_t'(poly_x[a]); t.az = ect_pkg::coord_t'(poly_z[a]);
    t.bx = ect_pkg::coord_t'(poly_x[b]); t.bz = ect_pkg::coord_t'(poly_z[b]);
    t.cx = ect_pkg::coord_t'(poly_x[c]); t.cz = ect_pkg::coord_t'(poly_z[c]);
    t.fin = 1'b0;
    t.drop = lost_any;
    pending_tris.push_back(t);
  endfunction

  // Triangles expected from the held polygon
  function automatic void clip_polygon();
    int n = held_count;
    int m, pa, pb, pc, q, first;
    longint area = 0;
    longint tv;
    bit found, blocked;
    if (n > 1 && poly_x[0] == poly_x[n-1] && poly_z[0] == poly_z[n-1]) n--;
    if (n < 3) return;
    for (int i = 0; i < n; i++)
      area += poly_x[i] * poly_z[(i+1)%n] - poly_x[(i+1)%n] * poly_z[i];
    if (area < 0) begin
      for (int i = 0; i < n/2; i++) begin
        tv = poly_x[i]; poly_x[i] = poly_x[n-1-i]; poly_x[n-1-i] = tv;
        tv = poly_z[i]; poly_z[i] = poly_z[n-1-i]; poly_z[n-1-i] = tv;
      end
    end
    for (int i = 0; i < n; i++) live_idx[i] = i;
    m = n;
    first = pending_tris.size();
    while (m > 3) begin
      found = 0;
      for (int i = 0; i < m && !found; i++) begin
        pa = live_idx[(i+m-1)%m];
        pb = live_idx[i];
        pc = live_idx[(i+1)%m];
        if (cross3(pa, pb, pc) <= 0) continue;
        blocked = 0;
        for (int k = 0; k < m && !blocked; k++) begin
          q = live_idx[k];
          if (q == pa || q == pb || q == pc) continue;
          if (in_or_on(q, pa, pb, pc)) blocked = 1;
        end
        if (blocked) continue;
        push_tri(pa, pb, pc);
        for (int k = i; k + 1 < m; k++) live_idx[k] = live_idx[k+1];
        m--;
        found = 1;
      end
      if (!found) break;
    end
    // fan of what is left (a single triangle normally)
    for (int i = 1; i + 1 < m; i++) push_tri(live_idx[0], live_idx[i], live_idx[i+1]);
    if (pending_tris.size() > first) pending_tris[$].fin = 1'b1;
  endfunction

  function automatic void accept_vertex(ect_pkg::coord_t x, ect_pkg::coord_t z,
                                        logic lastv);
    if (held_count < MaxV) begin
      poly_x[held_count] = longint'(x);
      poly_z[held_count] = longint'(z);
      held_count++;
    end else begin
      lost_any = 1;
    end
    if (lastv) begin
      clip_polygon();
      held_count = 0;
      lost_any = 0;
    end
  endfunction

  // Send one vertex request, with an optional idle burst first
  task automatic send_vertex(ect_pkg::coord_t x, ect_pkg::coord_t z, logic lastv);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vert_x <= x;
    vert_z <= z;
    last_vertex <= lastv;
    do @(posedge clk); while (in_stall);
    accept_vertex(x, z, lastv);
    items_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_poly(longint xs [$], longint zs [$]);
    for (int i = 0; i < xs.size(); i++)
      send_vertex(ect_pkg::coord_t'(xs[i]), ect_pkg::coord_t'(zs[i]),
                  i == xs.size() - 1);
  endtask

  // Output stall: random bursts, or one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_request = 0;
      end else if (!quiet && $urandom_range(2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Compare each taken triangle with the oldest expected one
  always @(posedge clk) begin
    tri_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tris.size() == 0) begin
        $error("unexpected triangle (%0d,%0d)(%0d,%0d)(%0d,%0d)", corner_a_x,
               corner_a_z, corner_b_x, corner_b_z, corner_c_x, corner_c_z);
        fail_count++;
      end else begin
        e = pending_tris.pop_front();
        if (corner_a_x !== e.ax) begin
          $error("corner_a_x expected %0d actual %0d", e.ax, corner_a_x); fail_count++;
        end
        if (corner_a_z !== e.az) begin
          $error("corner_a_z expected %0d actual %0d", e.az, corner_a_z); fail_count++;
        end
        if (corner_b_x !== e.bx) begin
          $error("corner_b_x expected %0d actual %0d", e.bx, corner_b_x); fail_count++;
        end
        if (corner_b_z !== e.bz) begin
          $error("corner_b_z expected %0d actual %0d", e.bz, corner_b_z); fail_count++;
        end
        if (corner_c_x !== e.cx) begin
          $error("corner_c_x expected %0d actual %0d", e.cx, corner_c_x); fail_count++;
        end
        if (corner_c_z !== e.cz) begin
          $error("corner_c_z expected %0d actual %0d", e.cz, corner_c_z); fail_count++;
        end
        if (final_triangle !== e.fin) begin
          $error("final_triangle expected %0b actual %0b", e.fin, final_triangle);
          fail_count++;
        end
        if (dropped_vertices !== e.drop) begin
          $error("dropped_vertices expected %0b actual %0b", e.drop, dropped_vertices);
          fail_count++;
        end
      end
    end
  end

  // Star shaped polygon around a centre; uneven radii give concave corners
  task automatic make_star(int n, output longint xs [$], output longint zs [$]);
    real ang, rad, rmax;
    longint cx, cz;
    xs = {}; zs = {};
    rmax = real'($urandom_range(16, 1 << 21));
    cx = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    cz = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    for (int i = 0; i < n; i++) begin
      ang = 6.283185307 * (real'(i) + 0.4 * ($urandom_range(1000) / 1000.0)) / n;
      rad = rmax * (0.2 + 0.8 * ($urandom_range(1000) / 1000.0));
      xs.push_back(cx + $rtoi(rad * $cos(ang)));
      zs.push_back(cz + $rtoi(rad * $sin(ang)));
    end
    if ($urandom_range(1)) begin
      xs.reverse(); zs.reverse();
    end
    if ($urandom_range(3) == 0) begin
      xs.push_back(xs[0]); zs.push_back(zs[0]);
    end
  endtask

  task automatic test_basic_shapes();
    // ccw triangle, cw square, closed square, concave arrow
    send_poly('{0, 256, 0}, '{0, 0, 256});
    send_poly('{0, 0, 512, 512}, '{0, 512, 512, 0});
    send_poly('{0, 512, 512, 0, 0}, '{0, 0, 512, 512, 0});
    send_poly('{0, 1024, 0, 300}, '{0, 0, 1024, 300});
  endtask

  task automatic test_small_polygons();
    // too few vertices, and a closed triangle down to two points
    send_poly('{5}, '{7});
    send_poly('{5, 9}, '{7, 1});
    send_poly('{3, 8, 3}, '{4, 2, 4});
  endtask

  task automatic test_extremes();
    send_poly('{-8388608, 8388607, 8388607, -8388608},
              '{-8388608, -8388608, 8388607, 8388607});
    // collinear points (no ear passes, fan fallback) and duplicate points
    send_poly('{0, 1, 2, 3}, '{0, 0, 0, 0});
    send_poly('{0, 4, 4, 4, 0}, '{0, 0, 4, 4, 4});
  endtask

  task automatic test_overflow();
    longint xs [$], zs [$];
    make_star(MaxV + 2, xs, zs);
    send_poly(xs, zs);
  endtask

  task automatic test_output_hold();
    longint xs [$], zs [$];
    hold_request = 1;
    for (int p = 0; p < 3; p++) begin
      make_star(6, xs, zs);
      send_poly(xs, zs);
    end
  endtask

  task automatic test_random_polygons(int target);
    longint xs [$], zs [$];
    int n, kind;
    while (items_sent < target) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(12, MaxV + 3) : $urandom_range(3, 8);
        make_star(n, xs, zs);
      end else begin
        // noise: raw coordinates over the full range or a tiny lattice
        n = $urandom_range(1, 9);
        xs = {}; zs = {};
        for (int i = 0; i < n; i++) begin
          if (kind == 9) begin
            xs.push_back($signed($urandom_range(6)) - 3);
            zs.push_back($signed($urandom_range(6)) - 3);
          end else begin
            xs.push_back(longint'(ect_pkg::coord_t'($urandom())));
            zs.push_back(longint'(ect_pkg::coord_t'($urandom())));
          end
        end
      end
      send_poly(xs, zs);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_basic_shapes();
    test_small_polygons();
    test_extremes();
    test_overflow();
    test_output_hold();
    test_random_polygons(440);
    quiet = 1;
    test_random_polygons(500);
    go_idle();
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
